[rtl/bdc_pkg.sv]
// Shared types and codes for the button debounce and click detector.
package bdc_pkg;

    localparam int NOW_WIDTH = 16;
    localparam int DELAY_WIDTH = 8;
    localparam int CFG_ADDR_WIDTH = 2;
    localparam int S_TDATA_WIDTH = 24;
    localparam int M_TDATA_WIDTH = 8;

    typedef logic [1:0] cmd_t;
    localparam cmd_t CMD_TICK        = 2'd0;
    localparam cmd_t CMD_GET_CLEAR   = 2'd1;
    localparam cmd_t CMD_TEST_CLICK  = 2'd2;
    localparam cmd_t CMD_TEST_DOUBLE = 2'd3;

    typedef logic [1:0] status_t;
    localparam status_t ST_INACTIVE = 2'd0;
    localparam status_t ST_ACTIVE   = 2'd1;
    localparam status_t ST_CLICKED  = 2'd2;
    localparam status_t ST_DOUBLE   = 2'd3;

    typedef logic [CFG_ADDR_WIDTH-1:0] cfg_addr_t;
    localparam cfg_addr_t REG_DEBOUNCE_DELAY     = 2'd0;
    localparam cfg_addr_t REG_CLICK_DELAY        = 2'd1;
    localparam cfg_addr_t REG_DOUBLE_CLICK_DELAY = 2'd2;

    typedef struct packed {
        logic [DELAY_WIDTH-1:0] debounce_delay;
        logic [DELAY_WIDTH-1:0] click_delay;
        logic [DELAY_WIDTH-1:0] double_click_delay;
    } cfg_t;

    typedef struct packed {
        logic [NOW_WIDTH-1:0] now_ticks;
        logic                 pin_level;
        cmd_t                 command;
    } item_t;

    typedef struct packed {
        logic    event_hit;
        status_t button_status;
    } result_t;

endpackage

[rtl/bdc_core.sv]
// Debounce state, click classification and queries: one item per fire cycle.
module bdc_core
    import bdc_pkg::*;
#(
    parameter int TIME_WIDTH = 16
) (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    fire,
    input  cfg_t    cfg,
    input  item_t   item,
    output result_t result
);

    logic                  deb_reg, deb_next;
    logic [TIME_WIDTH-1:0] stable_reg, stable_next;
    logic [TIME_WIDTH-1:0] press_reg, press_next;
    logic [TIME_WIDTH-1:0] release_reg, release_next;
    logic                  cp_reg, cp_next;
    logic                  dcp_reg, dcp_next;
    status_t               status_reg, status_next;

    logic                  pressed;
    logic [TIME_WIDTH-1:0] now;
    logic [TIME_WIDTH-1:0] dd, cd, dcd;
    logic                  flipped;
    logic                  deb1, cp1, cp2, dcp2;
    status_t               st1, st2;

    assign pressed = ~item.pin_level;
    assign now     = TIME_WIDTH'(item.now_ticks);
    assign dd      = TIME_WIDTH'(cfg.debounce_delay);
    assign cd      = TIME_WIDTH'(cfg.click_delay);
    assign dcd     = TIME_WIDTH'(cfg.double_click_delay);

    always_comb begin
        deb_next     = deb_reg;
        stable_next  = stable_reg;
        press_next   = press_reg;
        release_next = release_reg;
        cp_next      = cp_reg;
        dcp_next     = dcp_reg;
        status_next  = status_reg;
        result.button_status = status_reg;
        result.event_hit     = 1'b0;

        // debounce: elapsed time is the modulo difference of time stamps
        flipped = (pressed != deb_reg) && ((now - stable_reg) >= dd);
        deb1    = flipped ? pressed : deb_reg;
        cp1     = cp_reg | (flipped & pressed);

        // latched events survive ticks
        st1 = status_reg;
        if (status_reg != ST_CLICKED && status_reg != ST_DOUBLE) begin
            if (deb1) begin
                if (!cp1) begin
                    st1 = ST_ACTIVE;
                end
            end else begin
                st1 = ST_INACTIVE;
            end
        end

        // debounced release of a short press
        cp2  = cp1;
        dcp2 = dcp_reg;
        st2  = st1;
        if (flipped && !pressed && cp1) begin
            cp2 = 1'b0;
            if (dcp_reg) begin
                st2  = ST_DOUBLE;
                dcp2 = 1'b0;
            end else begin
                dcp2 = 1'b1;
            end
        end

        case (item.command)
            CMD_TICK: begin
                deb_next    = deb1;
                stable_next = (pressed == deb_reg) ? now : stable_reg;
                if (flipped && pressed) begin
                    press_next = now;
                end
                if (flipped && !pressed && cp1 && !dcp_reg) begin
                    release_next = now;
                end
                cp_next = cp2 && !((now - press_next) >= cd);
                dcp_next = dcp2;
                status_next = st2;
                if (dcp2 && ((now - release_next) >= dcd)) begin
                    dcp_next    = 1'b0;
                    status_next = ST_CLICKED;
                end
                result.button_status = status_next;
            end
            CMD_GET_CLEAR: begin
                if (status_reg == ST_CLICKED || status_reg == ST_DOUBLE) begin
                    status_next = ST_INACTIVE;
                end
            end
            CMD_TEST_CLICK: begin
                if (status_reg == ST_CLICKED) begin
                    status_next      = ST_INACTIVE;
                    result.event_hit = 1'b1;
                end
            end
            default: begin
                if (status_reg == ST_DOUBLE) begin
                    status_next      = ST_INACTIVE;
                    result.event_hit = 1'b1;
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            deb_reg     <= 1'b0;
            stable_reg  <= '0;
            press_reg   <= '0;
            release_reg <= '0;
            cp_reg      <= 1'b0;
            dcp_reg     <= 1'b0;
            status_reg  <= ST_INACTIVE;
        end else if (fire) begin
            deb_reg     <= deb_next;
            stable_reg  <= stable_next;
            press_reg   <= press_next;
            release_reg <= release_next;
            cp_reg      <= cp_next;
            dcp_reg     <= dcp_next;
            status_reg  <= status_next;
        end
    end

    a_hit_only_on_test: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && result.event_hit |->
            (item.command == CMD_TEST_CLICK || item.command == CMD_TEST_DOUBLE))
        else $error("event hit on a non-test command");

    a_query_keeps_timing: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && item.command != CMD_TICK |=>
            $stable(press_reg) && $stable(release_reg) && $stable(deb_reg)
            && $stable(stable_reg))
        else $error("query changed timing state");

    a_hit_clears_status: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && result.event_hit |=> status_reg == ST_INACTIVE)
        else $error("consumed event still latched");

    a_double_needs_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && item.command == CMD_TICK && status_reg != ST_DOUBLE
            && status_next == ST_DOUBLE |-> dcp_reg)
        else $error("double click without open window");

endmodule

[rtl/button_debounce_click_detector.sv]
// Top level: stream ports, configuration registers and the input and result stages.
//
// Usage: each s_ transaction carries one command. A tick (command 0) samples the
// raw active-low pin and a time stamp; queries (1 get state and clear, 2 test
// clicked, 3 test double clicked) read and consume latched click events.
// Every input transaction yields exactly one m_ transaction holding the button
// status and an event-hit flag.
// An accepted item goes to the input register, then the result register, which
// drives m_tvalid. Throughput: one transaction per cycle while m_tready is high;
// the state update in bdc_core is three TIME_WIDTH-bit subtractions and compares.
// Configuration: cfg_we writes register cfg_addr (0 debounce delay, 1 click
// delay, 2 double-click delay); other indexes are ignored. Write only while idle.
// Reset (aresetn low, synchronous) clears delays, timing state and both stages.
// Stall: while m_tready is low a result holds; one more item may wait in the
// input register, after which s_tready drops until the result is taken.
module button_debounce_click_detector
    import bdc_pkg::*;
#(
    parameter int TIME_WIDTH = 16
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      cfg_we,
    input  logic [CFG_ADDR_WIDTH-1:0] cfg_addr,
    input  logic [DELAY_WIDTH-1:0]    cfg_wdata,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    // command [1:0], pin_level [2], now_ticks [18:3], zero pad [23:19]
    input  logic [S_TDATA_WIDTH-1:0]  s_tdata,
    output logic                      m_tvalid,
    input  logic                      m_tready,
    // button_status [1:0], event_hit [2], zero pad [7:3]
    output logic [M_TDATA_WIDTH-1:0]  m_tdata
);

    cfg_t    cfg_reg;
    item_t   in_item_reg;
    logic    in_valid_reg;
    result_t out_result_reg;
    logic    out_valid_reg;
    result_t result;
    logic    advance;

    // move the held item into the result stage when that stage frees up
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                REG_DEBOUNCE_DELAY:     cfg_reg.debounce_delay     <= cfg_wdata;
                REG_CLICK_DELAY:        cfg_reg.click_delay        <= cfg_wdata;
                REG_DOUBLE_CLICK_DELAY: cfg_reg.double_click_delay <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_item_reg <= item_t'(s_tdata[$bits(item_t)-1:0]);
        end
        if (advance) begin
            out_result_reg <= result;
        end
    end

    bdc_core #(
        .TIME_WIDTH(TIME_WIDTH)
    ) u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .fire    (advance),
        .cfg     (cfg_reg),
        .item    (in_item_reg),
        .result  (result)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = M_TDATA_WIDTH'(out_result_reg);

    a_full_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && out_valid_reg && !m_tready |-> !s_tready)
        else $error("input accepted with both stages full");

    a_advance_fills_output: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> out_valid_reg)
        else $error("advanced item did not reach the result stage");

    a_stalled_result_kept: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && !m_tready |=> out_valid_reg && $stable(out_result_reg))
        else $error("stalled result lost");

endmodule
